// ----- rtl/core/sdl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Draw list package
// Shared types, operation and status codes for the sorted draw list.
// ----------------------------------------------------------------------------
package sdl_pkg;
  localparam int unsigned CAPACITY_DEF   = 32;
  localparam int unsigned ID_BITS_DEF    = 8;
  localparam int unsigned LAYER_BITS_DEF = 4;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SET_DEPTH = 3'd2,
    OP_SET_LAYER = 3'd3,
    OP_READ = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Shift command broadcast to every cell in the same cycle; enabled cells apply it.
  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_INSERT = 2'd1,
    SH_REMOVE = 2'd2
  } shift_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_PLACE = 2'd2,
    S_OUT = 2'd3
  } state_t;
endpackage
`default_nettype wire

// ----- rtl/core/sdl_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Draw list cell
// Holds one slot; compares against the broadcast key and id, and shifts
// with its neighbours on insert and remove.
// ----------------------------------------------------------------------------
module sdl_cell #(
  parameter int unsigned ID_BITS = 8,
  parameter int unsigned LAYER_BITS = 4
) (
  input  wire                    clk,
  input  wire sdl_pkg::shift_t   shift,
  input  wire                    sel_here,
  input  wire                    shift_en,
  input  wire [ID_BITS-1:0]      bc_id,
  input  wire [LAYER_BITS-1:0]   bc_layer,
  input  wire [15:0]             bc_depth,
  input  wire [ID_BITS-1:0]      left_id,
  input  wire [LAYER_BITS-1:0]   left_layer,
  input  wire [15:0]             left_depth,
  input  wire [ID_BITS-1:0]      right_id,
  input  wire [LAYER_BITS-1:0]   right_layer,
  input  wire [15:0]             right_depth,
  output logic [ID_BITS-1:0]     id_o,
  output logic [LAYER_BITS-1:0]  layer_o,
  output logic [15:0]            depth_o,
  output logic                   greater_o,
  output logic                   id_match_o
);
  import sdl_pkg::*;

  logic [ID_BITS-1:0]    id_r;
  logic [LAYER_BITS-1:0] layer_r;
  logic [15:0]           depth_r;

  assign id_o = id_r;
  assign layer_o = layer_r;
  assign depth_o = depth_r;
  assign id_match_o = (id_r == bc_id);
  // Layer first, then depth as a signed value.
  assign greater_o = (layer_r > bc_layer) ||
                     ((layer_r == bc_layer) && ($signed(depth_r) > $signed(bc_depth)));

  always_ff @(posedge clk) begin
    if (shift == SH_INSERT && shift_en) begin
      if (sel_here) begin
        id_r <= bc_id;
        layer_r <= bc_layer;
        depth_r <= bc_depth;
      end else begin
        id_r <= left_id;
        layer_r <= left_layer;
        depth_r <= left_depth;
      end
    end else if (shift == SH_REMOVE && shift_en) begin
      id_r <= right_id;
      layer_r <= right_layer;
      depth_r <= right_depth;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/stable_sorted_draw_list.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Stable sorted draw list
// Top level: sequencer over a row of slot cells.
// ----------------------------------------------------------------------------
// Keeps up to CAPACITY draw entries sorted by layer then signed depth, newer
// equal-key entries behind older ones. After a request is accepted the block
// goes through S_EXEC, then S_OUT, which offers the result; a set that moves
// the entry passes S_PLACE between them (S_EXEC takes the entry out, S_PLACE
// places it again). All cells compare in parallel and shift together, so the
// time taken does not depend on the fill. A new request is taken in the cycle
// after the previous result has been accepted, so the block works on one
// request at a time.
module stable_sorted_draw_list #(
  parameter int unsigned CAPACITY = sdl_pkg::CAPACITY_DEF,
  parameter int unsigned ID_BITS = sdl_pkg::ID_BITS_DEF,
  parameter int unsigned LAYER_BITS = sdl_pkg::LAYER_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  in_operation,
  input  wire  [7:0]  in_entry_id,
  input  wire  [3:0]  in_new_layer,
  input  wire  [15:0] in_new_depth,
  input  wire  [4:0]  in_read_index,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_status,
  output logic [4:0]  out_position,
  output logic [7:0]  out_out_id,
  output logic [3:0]  out_out_layer,
  output logic [15:0] out_out_depth,
  output logic [5:0]  out_fill_count
);
  import sdl_pkg::*;

  localparam int unsigned PB = $clog2(CAPACITY);
  localparam int unsigned CB = $clog2(CAPACITY + 1);

  state_t state_r, state_nxt;
  logic [2:0] op_r;
  logic [ID_BITS-1:0] id_r;
  logic [LAYER_BITS-1:0] lay_r;
  logic [15:0] dep_r;
  logic [4:0] ridx_r;
  logic [CB-1:0] cnt_r, cnt_nxt;

  logic [1:0] st_r;
  logic [4:0] pos_r;
  logic [7:0] oid_r;
  logic [3:0] olay_r;
  logic [15:0] odep_r;

  logic [ID_BITS-1:0]    c_id [CAPACITY];
  logic [LAYER_BITS-1:0] c_lay [CAPACITY];
  logic [15:0]           c_dep [CAPACITY];
  logic [CAPACITY-1:0]   c_gt, c_match, valid_v, ins_sel, ins_en, rem_en;
  shift_t shift;

  logic [PB-1:0] ins_pos, match_pos;
  logic ins_any, match_any;
  logic [PB:0] ins_pos_w;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) valid_v[i] = (i < int'(cnt_r));
  end

  // Priority encoders over the row of compare flags.
  always_comb begin
    ins_pos = '0; ins_any = 1'b0; match_pos = '0; match_any = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (c_gt[i] && valid_v[i]) begin ins_pos = PB'(i); ins_any = 1'b1; end
      if (c_match[i] && valid_v[i]) begin match_pos = PB'(i); match_any = 1'b1; end
    end
    ins_pos_w = ins_any ? {1'b0, ins_pos} : (PB+1)'(cnt_r);
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ins_sel[i] = ((PB+1)'(i) == ins_pos_w);
      ins_en[i] = ((PB+1)'(i) >= ins_pos_w);
      rem_en[i] = (PB'(i) >= match_pos);
    end
  end

  logic is_set, same;
  assign is_set = (op_r == OP_SET_DEPTH) || (op_r == OP_SET_LAYER);
  assign same = (op_r == OP_SET_DEPTH) ? (c_dep[match_pos] == dep_r)
                                       : (c_lay[match_pos] == lay_r);

  always_comb begin
    shift = SH_HOLD;
    if (state_r == S_EXEC) begin
      if (op_r == OP_INSERT && int'(cnt_r) < CAPACITY) shift = SH_INSERT;
      else if (op_r == OP_REMOVE && match_any) shift = SH_REMOVE;
      else if (is_set && match_any && !same) shift = SH_REMOVE;
    end else if (state_r == S_PLACE) begin
      shift = SH_INSERT;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int L = (g == 0) ? 0 : g - 1;
    localparam int R = (g == CAPACITY - 1) ? g : g + 1;
    sdl_cell #(.ID_BITS(ID_BITS), .LAYER_BITS(LAYER_BITS)) u_cell (
      .clk(clk), .shift(shift), .sel_here(ins_sel[g]),
      .shift_en((shift == SH_INSERT) ? ins_en[g] : rem_en[g]),
      .bc_id(id_r), .bc_layer(lay_r), .bc_depth(dep_r),
      .left_id(c_id[L]), .left_layer(c_lay[L]), .left_depth(c_dep[L]),
      .right_id(c_id[R]), .right_layer(c_lay[R]), .right_depth(c_dep[R]),
      .id_o(c_id[g]), .layer_o(c_lay[g]), .depth_o(c_dep[g]),
      .greater_o(c_gt[g]), .id_match_o(c_match[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = (is_set && match_any && !same) ? S_PLACE : S_OUT;
      S_PLACE: state_nxt = S_OUT;
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (shift == SH_INSERT) cnt_nxt = cnt_r + CB'(1);
    else if (shift == SH_REMOVE) cnt_nxt = cnt_r - CB'(1);
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = st_r;
  assign out_position = pos_r;
  assign out_out_id = oid_r;
  assign out_out_layer = olay_r;
  assign out_out_depth = odep_r;
  assign out_fill_count = 6'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r <= in_operation;
      id_r <= ID_BITS'(in_entry_id);
      lay_r <= LAYER_BITS'(in_new_layer);
      dep_r <= in_new_depth;
      ridx_r <= in_read_index;
    end else if (state_r == S_EXEC) begin
      st_r <= ST_OK; pos_r <= '0; oid_r <= '0; olay_r <= '0; odep_r <= '0;
      case (op_r)
        OP_INSERT: begin
          oid_r <= 8'(id_r); olay_r <= 4'(lay_r); odep_r <= dep_r;
          if (int'(cnt_r) < CAPACITY) pos_r <= 5'(ins_pos_w);
          else st_r <= ST_FULL;
        end
        OP_REMOVE, OP_SET_DEPTH, OP_SET_LAYER: begin
          oid_r <= 8'(id_r);
          if (!match_any) st_r <= ST_NOT_FOUND;
          else begin
            pos_r <= 5'(match_pos);
            olay_r <= 4'(c_lay[match_pos]);
            odep_r <= c_dep[match_pos];
            // The moved entry is rebroadcast with its new key.
            if (op_r == OP_SET_DEPTH) lay_r <= c_lay[match_pos];
            else if (op_r == OP_SET_LAYER) dep_r <= c_dep[match_pos];
          end
        end
        OP_READ: begin
          if (32'(ridx_r) >= 32'(cnt_r) || 32'(ridx_r) >= CAPACITY) st_r <= ST_RANGE;
          else begin
            pos_r <= ridx_r;
            oid_r <= 8'(c_id[PB'(ridx_r)]);
            olay_r <= 4'(c_lay[PB'(ridx_r)]);
            odep_r <= c_dep[PB'(ridx_r)];
          end
        end
        default: ;
      endcase
    end else if (state_r == S_PLACE) begin
      pos_r <= 5'(ins_pos_w);
      olay_r <= 4'(lay_r);
      odep_r <= dep_r;
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= CAPACITY) else $error("fill count above capacity");
  a_place_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PLACE |=> $past(cnt_r, 2) == cnt_r) else $error("set changed fill");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(cnt_r)) else $error("result lost");
`endif
endmodule
`default_nettype wire

// ----- dv/sdl_checker.sv -----
// ----------------------------------------------------------------------------
// Draw list checker
// Watches both channels of the sorted draw list, keeps its own copy of the
// list, predicts the result of every accepted request and compares each
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sdl_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [2:0]  in_operation,
  input  wire  [7:0]  in_entry_id,
  input  wire  [3:0]  in_new_layer,
  input  wire  [15:0] in_new_depth,
  input  wire  [4:0]  in_read_index,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [1:0]  out_status,
  input  wire  [4:0]  out_position,
  input  wire  [7:0]  out_out_id,
  input  wire  [3:0]  out_out_layer,
  input  wire  [15:0] out_out_depth,
  input  wire  [5:0]  out_fill_count,
  output int          fail_count,
  output int          pending
);
  import sdl_pkg::*;

  localparam int CAP = 32;

  typedef struct packed {
    logic [7:0]  id;
    logic [3:0]  layer;
    logic [15:0] depth;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  position;
    logic [7:0]  id;
    logic [3:0]  layer;
    logic [15:0] depth;
    logic [5:0]  fill;
  } outcome_t;

  entry_t   shadow_list[$];
  outcome_t expected_outcomes[$];

  function automatic logic [19:0] order_key(logic [3:0] layer, logic [15:0] depth);
    return {layer, ~depth[15], depth[14:0]};
  endfunction

  // Goes after every entry with an equal key, so ties keep placement order.
  function automatic int place_entry(entry_t e);
    int pos;
    pos = shadow_list.size();
    for (int i = 0; i < shadow_list.size(); i++) begin
      if (order_key(shadow_list[i].layer, shadow_list[i].depth) >
          order_key(e.layer, e.depth)) begin
        pos = i;
        break;
      end
    end
    shadow_list.insert(pos, e);
    return pos;
  endfunction

  function automatic outcome_t predict_outcome(logic [2:0] op, logic [7:0] id,
                                               logic [3:0] layer, logic [15:0] depth,
                                               logic [4:0] idx);
    outcome_t r;
    entry_t e;
    int found;
    r = '0;
    r.status = ST_OK;
    found = -1;
    if (op inside {OP_REMOVE, OP_SET_DEPTH, OP_SET_LAYER}) begin
      for (int i = 0; i < shadow_list.size(); i++) begin
        if (shadow_list[i].id == id) begin
          found = i;
          break;
        end
      end
    end
    case (op)
      OP_INSERT: begin
        r.id = id;
        r.layer = layer;
        r.depth = depth;
        if (shadow_list.size() >= CAP) r.status = ST_FULL;
        else r.position = 5'(place_entry('{id, layer, depth}));
      end
      OP_REMOVE, OP_SET_DEPTH, OP_SET_LAYER: begin
        r.id = id;
        if (found < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          e = shadow_list[found];
          r.position = 5'(found);
          if (op == OP_REMOVE) begin
            shadow_list.delete(found);
          end else if ((op == OP_SET_DEPTH && e.depth != depth) ||
                       (op == OP_SET_LAYER && e.layer != layer)) begin
            if (op == OP_SET_DEPTH) e.depth = depth;
            else e.layer = layer;
            shadow_list.delete(found);
            r.position = 5'(place_entry(e));
          end
          r.layer = e.layer;
          r.depth = e.depth;
        end
      end
      OP_READ: begin
        if (idx >= shadow_list.size()) begin
          r.status = ST_RANGE;
        end else begin
          r.position = idx;
          r.id = shadow_list[idx].id;
          r.layer = shadow_list[idx].layer;
          r.depth = shadow_list[idx].depth;
        end
      end
      default: ;
    endcase
    r.fill = 6'(shadow_list.size());
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      shadow_list.delete();
      expected_outcomes.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_outcomes.insert(expected_outcomes.size(),
                                 predict_outcome(in_operation, in_entry_id,
                                                 in_new_layer, in_new_depth,
                                                 in_read_index));
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_outcomes.pop_front();
          if (out_status != want.status || out_position != want.position ||
              out_out_id != want.id || out_out_layer != want.layer ||
              out_out_depth != want.depth || out_fill_count != want.fill)
            fail_count <= fail_count + 1;
          if (out_status != want.status)
            $error("status: expected %0d, got %0d", want.status, out_status);
          if (out_position != want.position)
            $error("position: expected %0d, got %0d", want.position, out_position);
          if (out_out_id != want.id)
            $error("out_id: expected %0d, got %0d", want.id, out_out_id);
          if (out_out_layer != want.layer)
            $error("out_layer: expected %0d, got %0d", want.layer, out_out_layer);
          if (out_out_depth != want.depth)
            $error("out_depth: expected %0d, got %0d", $signed(want.depth),
                   $signed(out_out_depth));
          if (out_fill_count != want.fill)
            $error("fill_count: expected %0d, got %0d", want.fill, out_fill_count);
        end
      end
    end
    pending <= expected_outcomes.size();
  end
endmodule

// ----- dv/tb_stable_sorted_draw_list.sv -----
// ----------------------------------------------------------------------------
// Draw list testbench
// Drives directed and random requests into the sorted draw list with bursty
// input and a stalling receiver; the checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb_stable_sorted_draw_list;
  import sdl_pkg::*;

  localparam int RANDOM_REQUESTS = 1030;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [2:0]  in_operation = '0;
  logic [7:0]  in_entry_id = '0;
  logic [3:0]  in_new_layer = '0;
  logic [15:0] in_new_depth = '0;
  logic [4:0]  in_read_index = '0;
  logic        out_stall = 1'b1;
  logic        long_hold = 1'b0;
  wire         in_stall;
  wire         out_valid;
  wire  [1:0]  out_status;
  wire  [4:0]  out_position;
  wire  [7:0]  out_out_id;
  wire  [3:0]  out_out_layer;
  wire  [15:0] out_out_depth;
  wire  [5:0]  out_fill_count;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  logic [7:0]  live_ids[$];

  always #5 clk = ~clk;

  stable_sorted_draw_list dut (.*);

  sdl_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver stalls on its own pattern, with stretches of no stalling.
  always @(posedge clk) begin
    int mode;
    mode = (cycle_count / 300) % 3;
    if (long_hold) out_stall <= 1'b1;
    else if (mode == 0) out_stall <= 1'b0;
    else if (mode == 1) out_stall <= ($urandom_range(3) == 0);
    else out_stall <= ($urandom_range(1) == 0);
  end

  task automatic send_request(op_t op, logic [7:0] id, logic [3:0] layer,
                              logic [15:0] depth, logic [4:0] idx);
    in_valid <= 1'b1;
    in_operation <= op;
    in_entry_id <= id;
    in_new_layer <= layer;
    in_new_depth <= depth;
    in_read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_INSERT) live_ids.insert(live_ids.size(), id);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_random();
    int pick;
    logic [7:0] id;
    pick = $urandom_range(99);
    id = (live_ids.size() > 0 && $urandom_range(4) != 0) ?
         live_ids[$urandom_range(live_ids.size() - 1)] : 8'($urandom);
    if (pick < 35)
      send_request(OP_INSERT, ($urandom_range(3) == 0) ? 8'($urandom_range(7)) : 8'($urandom),
                   4'($urandom_range(3) == 0 ? $urandom_range(1) : $urandom),
                   16'($urandom_range(2) == 0 ? $urandom_range(3) - 1 : $urandom),
                   5'($urandom));
    else if (pick < 50) send_request(OP_REMOVE, id, 4'($urandom), 16'($urandom), 5'($urandom));
    else if (pick < 63) send_request(OP_SET_DEPTH, id, 4'($urandom),
                                     16'($urandom_range(2) == 0 ? 0 : $urandom), 5'($urandom));
    else if (pick < 76) send_request(OP_SET_LAYER, id, 4'($urandom_range(3)),
                                     16'($urandom), 5'($urandom));
    else if (pick < 97) send_request(OP_READ, 8'($urandom), 4'($urandom), 16'($urandom),
                                     5'($urandom));
    else send_request(op_t'($urandom_range(7, 5)), 8'($urandom), 4'($urandom),
                      16'($urandom), 5'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list cases, extremes, equal keys and two of the unused codes.
    send_request(OP_READ, 8'd0, 4'd0, 16'd0, 5'd0);
    send_request(OP_REMOVE, 8'd9, 4'd0, 16'd0, 5'd0);
    send_request(OP_SET_DEPTH, 8'd9, 4'd0, 16'd5, 5'd0);
    send_request(OP_INSERT, 8'd1, 4'd5, 16'h0010, 5'd0);
    send_request(OP_SET_LAYER, 8'd1, 4'd9, 16'd0, 5'd0);
    send_request(OP_SET_DEPTH, 8'd1, 4'd0, 16'h0010, 5'd0);
    send_request(OP_INSERT, 8'hFF, 4'hF, 16'h7FFF, 5'd31);
    send_request(OP_INSERT, 8'h00, 4'h0, 16'h8000, 5'd0);
    send_request(OP_INSERT, 8'h20, 4'h9, 16'h0010, 5'd0);
    send_request(OP_INSERT, 8'h21, 4'h9, 16'h0010, 5'd0);
    send_request(OP_INSERT, 8'h20, 4'h9, 16'hFFFF, 5'd0);
    send_request(OP_SET_LAYER, 8'h20, 4'h9, 16'd0, 5'd0);
    send_request(OP_SET_DEPTH, 8'h20, 4'h0, 16'h0010, 5'd0);
    send_request(OP_READ, 8'd0, 4'd0, 16'd0, 5'd2);
    send_request(OP_READ, 8'd0, 4'd0, 16'd0, 5'd31);
    send_request(OP_REMOVE, 8'h20, 4'd0, 16'd0, 5'd0);
    send_request(op_t'(3'd5), 8'hAA, 4'hA, 16'hAAAA, 5'd10);
    send_request(op_t'(3'd7), 8'h55, 4'h5, 16'h5555, 5'd21);
    for (int i = 0; i < 30; i++)
      send_request(OP_INSERT, 8'(i + 64), 4'(i % 3), 16'(i * 1000), 5'd0);
    send_request(OP_INSERT, 8'h80, 4'h2, 16'd0, 5'd0);
    send_request(OP_READ, 8'd0, 4'd0, 16'd0, 5'd31);
    // Sender waits until every outstanding result has come. The count of
    // outstanding requests is registered, so it is read after the next edge.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Receiver holds off while the sender keeps offering requests.
    long_hold <= 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        long_hold <= 1'b0;
      end
      for (int i = 0; i < 10; i++) send_random();
    join

    for (int n = 0; n < RANDOM_REQUESTS; ) begin
      int burst;
      burst = $urandom_range(20, 1);
      for (int b = 0; b < burst; b++) begin
        send_random();
        n++;
      end
      if ($urandom_range(2) != 0) pause_sender($urandom_range(6));
      // Clear the testbench's record of inserted ids once it grows past 200.
      if (live_ids.size() > 200) live_ids.delete();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// ----- stable_sorted_draw_list.f -----
rtl/core/sdl_pkg.sv
rtl/core/sdl_cell.sv
rtl/core/stable_sorted_draw_list.sv
dv/sdl_checker.sv
dv/tb_stable_sorted_draw_list.sv
